/* src/rel_pkg.sv */
// Shared constants and types for the rotated ellipsoid level value block.
package rel_pkg;

   localparam int CSR_INDEX_WIDTH = 4;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_CENTER_X     = 4'd0;
   localparam csr_index_type CSR_CENTER_Y     = 4'd1;
   localparam csr_index_type CSR_CENTER_Z     = 4'd2;
   localparam csr_index_type CSR_INV_WIDTH_X  = 4'd3;
   localparam csr_index_type CSR_INV_WIDTH_Y  = 4'd4;
   localparam csr_index_type CSR_INV_WIDTH_Z  = 4'd5;
   localparam csr_index_type CSR_TILT_COS_SIN = 4'd6;
   localparam csr_index_type CSR_PLANE_COS_SIN = 4'd7;

   localparam int COORD_FRAC  = 16;
   localparam int INVW_WIDTH  = 24;
   localparam int MAG_WIDTH   = 32;
   localparam int SQ_WIDTH    = 64;
   localparam int SUM_WIDTH   = 66;
   localparam int ROOT_WIDTH  = 32;
   localparam int REM_WIDTH   = 35;
   localparam int SQRT_STEPS  = 4;
   localparam int SQRT_STAGES = ROOT_WIDTH / SQRT_STEPS;

   localparam logic [INVW_WIDTH-1:0] INVW_ONE = 24'd65536;

endpackage

/* src/rel_rotate.sv */
// Centre offset and two-angle rotation pipeline (five stages).
module rel_rotate #(
   parameter int COORD_WIDTH    = 32,
   parameter int TRIG_FRAC_BITS = 16,
   localparam int TW = TRIG_FRAC_BITS + 2,
   localparam int DW = COORD_WIDTH + 1,
   localparam int AW = DW + 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic signed [COORD_WIDTH-1:0] center_x,
   input  logic signed [COORD_WIDTH-1:0] center_y,
   input  logic signed [COORD_WIDTH-1:0] center_z,
   input  logic signed [TW-1:0]          tilt_cos,
   input  logic signed [TW-1:0]          tilt_sin,
   input  logic signed [TW-1:0]          plane_cos,
   input  logic signed [TW-1:0]          plane_sin,
   output logic                          out_valid,
   output logic signed [AW-1:0]          axis_0,
   output logic signed [AW-1:0]          axis_1,
   output logic signed [AW-1:0]          axis_2
);

   localparam int PW  = DW + TW;
   localparam int RW1 = PW + 2;
   localparam int WW  = RW1 - TRIG_FRAC_BITS;
   localparam int QW  = WW + TW;
   localparam int RW2 = QW + 2;
   localparam int A2W = WW;

   logic [4:0] valid_ff;

   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [PW-1:0] ycp_ff, zsp_ff, ysp_ff, zcp_ff, xct_ff, xst_ff;
   logic signed [PW-1:0] xct2_ff, xst2_ff, xct3_ff, xst3_ff;
   logic signed [WW-1:0] w_ff;
   logic signed [A2W-1:0] a2_ff, a2b_ff;
   logic signed [QW-1:0] wst_ff, wct_ff;
   logic signed [AW-1:0] a0_ff, a1_ff, a2c_ff;

   logic signed [RW1-1:0] wsum_in, a2sum_in;
   logic signed [RW2-1:0] a0sum_in, a1sum_in;

   always_comb begin
      wsum_in  = RW1'(ycp_ff) + RW1'(zsp_ff) + (RW1'(1) << (TRIG_FRAC_BITS - 1));
      a2sum_in = RW1'(zcp_ff) - RW1'(ysp_ff) + (RW1'(1) << (TRIG_FRAC_BITS - 1));
      a0sum_in = RW2'(xct3_ff) + RW2'(wst_ff) + (RW2'(1) << (TRIG_FRAC_BITS - 1));
      a1sum_in = RW2'(wct_ff) - RW2'(xst3_ff) + (RW2'(1) << (TRIG_FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= DW'(point_x) - DW'(center_x);
      dy_ff <= DW'(point_y) - DW'(center_y);
      dz_ff <= DW'(point_z) - DW'(center_z);

      ycp_ff <= PW'(dy_ff) * PW'(plane_cos);
      zsp_ff <= PW'(dz_ff) * PW'(plane_sin);
      ysp_ff <= PW'(dy_ff) * PW'(plane_sin);
      zcp_ff <= PW'(dz_ff) * PW'(plane_cos);
      xct_ff <= PW'(dx_ff) * PW'(tilt_cos);
      xst_ff <= PW'(dx_ff) * PW'(tilt_sin);

      w_ff    <= wsum_in[RW1-1:TRIG_FRAC_BITS];
      a2_ff   <= a2sum_in[RW1-1:TRIG_FRAC_BITS];
      xct2_ff <= xct_ff;
      xst2_ff <= xst_ff;

      wst_ff  <= QW'(w_ff) * QW'(tilt_sin);
      wct_ff  <= QW'(w_ff) * QW'(tilt_cos);
      xct3_ff <= xct2_ff;
      xst3_ff <= xst2_ff;
      a2b_ff  <= a2_ff;

      a0_ff  <= AW'(a0sum_in[RW2-1:TRIG_FRAC_BITS]);
      a1_ff  <= AW'(a1sum_in[RW2-1:TRIG_FRAC_BITS]);
      a2c_ff <= AW'(a2b_ff);
   end

   assign out_valid = valid_ff[4];
   assign axis_0    = a0_ff;
   assign axis_1    = a1_ff;
   assign axis_2    = a2c_ff;

endmodule

/* src/rel_scale.sv */
// Axis scaling, squaring and sum of squares (four stages).
module rel_scale #(
   parameter int AXIS_WIDTH = 41
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [AXIS_WIDTH-1:0]           axis_0,
   input  logic signed [AXIS_WIDTH-1:0]           axis_1,
   input  logic signed [AXIS_WIDTH-1:0]           axis_2,
   input  logic [rel_pkg::INVW_WIDTH-1:0]         inv_width_x,
   input  logic [rel_pkg::INVW_WIDTH-1:0]         inv_width_y,
   input  logic [rel_pkg::INVW_WIDTH-1:0]         inv_width_z,
   output logic                                   out_valid,
   output logic [rel_pkg::SQ_WIDTH-1:0]           sum_sq,
   output logic                                   overflow
);

   localparam int PRW = AXIS_WIDTH + rel_pkg::INVW_WIDTH + 1;
   localparam int RDW = PRW + 1;
   localparam int QW  = RDW - rel_pkg::COORD_FRAC;
   localparam int MW  = rel_pkg::MAG_WIDTH;

   logic [3:0] valid_ff;

   logic signed [PRW-1:0] prod_ff [3];
   logic [MW-1:0]         mag_ff [3];
   logic [2:0]            big_ff;
   logic [rel_pkg::SQ_WIDTH-1:0] sq_ff [3];
   logic                  big2_ff;
   logic [rel_pkg::SQ_WIDTH-1:0] sum_ff;
   logic                  ovf_ff;

   logic signed [AXIS_WIDTH-1:0] axis_v [3];
   logic [rel_pkg::INVW_WIDTH-1:0] inv_v [3];
   logic signed [RDW-1:0] rnd_in [3];
   logic signed [QW-1:0]  q_in [3];
   logic [QW-1:0]         mag_in [3];
   logic [rel_pkg::SUM_WIDTH-1:0] sum_in;

   always_comb begin
      axis_v[0] = axis_0;
      axis_v[1] = axis_1;
      axis_v[2] = axis_2;
      inv_v[0]  = inv_width_x;
      inv_v[1]  = inv_width_y;
      inv_v[2]  = inv_width_z;
      for (int i = 0; i < 3; i++) begin
         rnd_in[i] = RDW'(prod_ff[i]) + (RDW'(1) << (rel_pkg::COORD_FRAC - 1));
         q_in[i]   = rnd_in[i][RDW-1:rel_pkg::COORD_FRAC];
         mag_in[i] = q_in[i][QW-1] ? (~q_in[i] + QW'(1)) : q_in[i];
      end
      sum_in = rel_pkg::SUM_WIDTH'(sq_ff[0]) + rel_pkg::SUM_WIDTH'(sq_ff[1])
             + rel_pkg::SUM_WIDTH'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= PRW'(axis_v[i]) * PRW'($signed({1'b0, inv_v[i]}));
         mag_ff[i]  <= mag_in[i][MW-1:0];
         big_ff[i]  <= |mag_in[i][QW-1:MW];
         sq_ff[i]   <= rel_pkg::SQ_WIDTH'(mag_ff[i]) * rel_pkg::SQ_WIDTH'(mag_ff[i]);
      end
      big2_ff <= |big_ff;
      sum_ff  <= sum_in[rel_pkg::SQ_WIDTH-1:0];
      ovf_ff  <= big2_ff | (|sum_in[rel_pkg::SUM_WIDTH-1:rel_pkg::SQ_WIDTH]);
   end

   assign out_valid = valid_ff[3];
   assign sum_sq    = sum_ff;
   assign overflow  = ovf_ff;

endmodule

/* src/rel_isqrt.sv */
// Pipelined digit-by-digit floor square root, four root bits per stage.
module rel_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [rel_pkg::SQ_WIDTH-1:0]     radicand,
   input  logic                             in_flag,
   output logic                             out_valid,
   output logic [rel_pkg::ROOT_WIDTH-1:0]   root,
   output logic                             out_flag
);

   localparam int NS = rel_pkg::SQRT_STAGES;
   localparam int RW = rel_pkg::REM_WIDTH;
   localparam int SW = rel_pkg::SQ_WIDTH;
   localparam int OW = rel_pkg::ROOT_WIDTH;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] flag_ff;
   logic [RW-1:0] rem_ff  [NS];
   logic [OW-1:0] root_ff [NS];
   logic [SW-1:0] rad_ff  [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      logic [RW-1:0] rem_src, rem_in;
      logic [OW-1:0] root_src, root_in;
      logic [SW-1:0] rad_src, rad_in;
      logic          flag_src;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
         assign flag_src = in_flag;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign flag_src = flag_ff[s-1];
      end

      always_comb begin
         logic [RW-1:0] trial;
         rem_in  = rem_src;
         root_in = root_src;
         rad_in  = rad_src;
         for (int k = 0; k < rel_pkg::SQRT_STEPS; k++) begin
            rem_in = {rem_in[RW-3:0], rad_in[SW-1:SW-2]};
            rad_in = {rad_in[SW-3:0], 2'b00};
            trial  = RW'({root_in, 2'b01});
            if (rem_in >= trial) begin
               rem_in  = rem_in - trial;
               root_in = {root_in[OW-2:0], 1'b1};
            end else begin
               root_in = {root_in[OW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
         rad_ff[s]  <= rad_in;
         flag_ff[s] <= flag_src;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign root      = root_ff[NS-1];
   assign out_flag  = flag_ff[NS-1];

endmodule

/* src/rotated_ellipsoid_level_value.sv */
// Top level: configuration registers, pipeline and saturating level output.
//
//  channel  ports                               transfer
//  request  start, busy, req_point_*            start & !busy
//  result   rsp_valid, rsp_level_value, rsp_saturated   one-cycle strobe
//  config   csr_valid, csr_ready, csr_index, csr_data   csr_valid & csr_ready
//
// One point per cycle; busy is never raised. Pipeline stages: 5 rotate,
// 4 scale and square, 8 square root (4 bits per stage), 1 output.
// Synchronous reset clears valid bits and centres; unit scale, zero angles.
// The receiver cannot stall; results leave on rsp_valid without backpressure.
module rotated_ellipsoid_level_value #(
   parameter int COORD_WIDTH    = 32,
   parameter int TRIG_FRAC_BITS = 16,
   localparam int TW  = TRIG_FRAC_BITS + 2,
   localparam int CDW = (COORD_WIDTH > 2 * TW) ? COORD_WIDTH : 2 * TW
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  logic signed [COORD_WIDTH-1:0]         req_point_z,
   output logic                                  rsp_valid,
   output logic signed [COORD_WIDTH-1:0]         rsp_level_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rel_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CDW-1:0]                        csr_data
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int AW = DW + 8;
   localparam int IW = rel_pkg::INVW_WIDTH;
   localparam int LW = ((COORD_WIDTH > 33) ? COORD_WIDTH : 33) + 2;
   localparam logic signed [LW-1:0] MIN_LEVEL =
      {{(LW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

   logic signed [COORD_WIDTH-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [IW-1:0] inv_x_ff, inv_y_ff, inv_z_ff;
   logic [2*TW-1:0] tilt_ff, plane_ff;

   logic rot_valid;
   logic signed [AW-1:0] axis_0, axis_1, axis_2;
   logic scl_valid, scl_ovf;
   logic [rel_pkg::SQ_WIDTH-1:0] sum_sq;
   logic sq_valid, sq_ovf;
   logic [rel_pkg::ROOT_WIDTH-1:0] root;

   logic valid_ff, sat_ff;
   logic signed [COORD_WIDTH-1:0] level_ff;
   logic signed [LW-1:0] level_in;
   logic sat_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         inv_x_ff    <= rel_pkg::INVW_ONE;
         inv_y_ff    <= rel_pkg::INVW_ONE;
         inv_z_ff    <= rel_pkg::INVW_ONE;
         tilt_ff     <= {TW'(1) << TRIG_FRAC_BITS, TW'(0)};
         plane_ff    <= {TW'(1) << TRIG_FRAC_BITS, TW'(0)};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rel_pkg::CSR_CENTER_X:      center_x_ff <= csr_data[COORD_WIDTH-1:0];
            rel_pkg::CSR_CENTER_Y:      center_y_ff <= csr_data[COORD_WIDTH-1:0];
            rel_pkg::CSR_CENTER_Z:      center_z_ff <= csr_data[COORD_WIDTH-1:0];
            rel_pkg::CSR_INV_WIDTH_X:   inv_x_ff    <= csr_data[IW-1:0];
            rel_pkg::CSR_INV_WIDTH_Y:   inv_y_ff    <= csr_data[IW-1:0];
            rel_pkg::CSR_INV_WIDTH_Z:   inv_z_ff    <= csr_data[IW-1:0];
            rel_pkg::CSR_TILT_COS_SIN:  tilt_ff     <= csr_data[2*TW-1:0];
            rel_pkg::CSR_PLANE_COS_SIN: plane_ff    <= csr_data[2*TW-1:0];
            default: ;
         endcase
      end
   end

   rel_rotate #(
      .COORD_WIDTH   (COORD_WIDTH),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .point_z   (req_point_z),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .center_z  (center_z_ff),
      .tilt_cos  ($signed(tilt_ff[2*TW-1:TW])),
      .tilt_sin  ($signed(tilt_ff[TW-1:0])),
      .plane_cos ($signed(plane_ff[2*TW-1:TW])),
      .plane_sin ($signed(plane_ff[TW-1:0])),
      .out_valid (rot_valid),
      .axis_0    (axis_0),
      .axis_1    (axis_1),
      .axis_2    (axis_2)
   );

   rel_scale #(
      .AXIS_WIDTH(AW)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rot_valid),
      .axis_0     (axis_0),
      .axis_1     (axis_1),
      .axis_2     (axis_2),
      .inv_width_x(inv_x_ff),
      .inv_width_y(inv_y_ff),
      .inv_width_z(inv_z_ff),
      .out_valid  (scl_valid),
      .sum_sq     (sum_sq),
      .overflow   (scl_ovf)
   );

   rel_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (scl_valid),
      .radicand (sum_sq),
      .in_flag  (scl_ovf),
      .out_valid(sq_valid),
      .root     (root),
      .out_flag (sq_ovf)
   );

   always_comb begin
      level_in = (LW'(1) << rel_pkg::COORD_FRAC) - LW'(root);
      sat_in   = sq_ovf || (level_in < MIN_LEVEL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff   <= sat_in;
      level_ff <= sat_in ? MIN_LEVEL[COORD_WIDTH-1:0] : level_in[COORD_WIDTH-1:0];
   end

   assign rsp_valid       = valid_ff;
   assign rsp_level_value = level_ff;
   assign rsp_saturated   = sat_ff;

endmodule
